FILE: rtl/core/ooc_pkg.sv
// Shared types and constants for the obstacle overtake controller.
package ooc_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int SPEED_W    = 4;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRUISE_SPEED      = 3'd0,
		REG_APPROACH_SPEED    = 3'd1,
		REG_COLLIDE_SCALE     = 3'd2,
		REG_SIDE_NEAR_LOW     = 3'd3,
		REG_SIDE_NEAR_HIGH    = 3'd4,
		REG_FRONT_CLEAR_LIMIT = 3'd5,
		REG_REAR_CLEAR_LOW    = 3'd6,
		REG_REAR_CLEAR_HIGH   = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [SPEED_W-1:0]    RST_CRUISE_SPEED      = 4'd6;
	localparam logic [SPEED_W-1:0]    RST_APPROACH_SPEED    = 4'd3;
	localparam logic [CFG_DATA_W-1:0] RST_COLLIDE_SCALE     = 8'd100;
	localparam logic [CFG_DATA_W-1:0] RST_SIDE_NEAR_LOW     = 8'd6;
	localparam logic [CFG_DATA_W-1:0] RST_SIDE_NEAR_HIGH    = 8'd20;
	localparam logic [CFG_DATA_W-1:0] RST_FRONT_CLEAR_LIMIT = 8'd3;
	localparam logic [CFG_DATA_W-1:0] RST_REAR_CLEAR_LOW    = 8'd4;
	localparam logic [CFG_DATA_W-1:0] RST_REAR_CLEAR_HIGH   = 8'd25;

	// Controller flags carried from one tick to the next
	typedef struct packed {
		logic obstacle;
		logic side_seen;
		logic beside;
		logic pass_done;
		logic left;
		logic right;
	} ctrl_flags_t;

endpackage

FILE: rtl/core/ooc_if.sv
// Valid/ready channel interfaces for sensor ticks and controller results.
interface ooc_in_if #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] front_distance;
	logic signed [SAMPLE_BITS-1:0] front_side_distance;
	logic signed [SAMPLE_BITS-1:0] rear_side_distance;
	logic signed [SAMPLE_BITS-1:0] rear_distance;

	modport source (output valid, front_distance, front_side_distance,
		rear_side_distance, rear_distance, input ready);
	modport sink (input valid, front_distance, front_side_distance,
		rear_side_distance, rear_distance, output ready);
endinterface

interface ooc_out_if import ooc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               obstacle_active;
	logic               left_blink;
	logic               right_blink;
	logic [SPEED_W-1:0] drive_speed;
	logic               passing_now;

	modport source (output valid, obstacle_active, left_blink, right_blink,
		drive_speed, passing_now, input ready);
	modport sink (input valid, obstacle_active, left_blink, right_blink,
		drive_speed, passing_now, output ready);
endinterface

FILE: rtl/core/obstacle_overtake_controller.sv
// Obstacle overtake controller: windowed distance sums and overtake sequencing.
//
//   channel   dir   handshake       payload
//   sample    in    valid/ready     four signed distance readings
//   result    out   valid/ready     obstacle, blinkers, speed, beside
//   cfg       in    cfg_we          cfg_index, cfg_data (write only)
//
// One tick is accepted per clock while the result is not stalled; a tick passes
// through the input register, then the window update and flag logic into the result register.
// Each window is a shift line with a running sum, so one add/subtract per
// channel and one 8x4 multiply for the collision threshold set the path.
// Reset clears windows-primed, flags and valids; speed returns to 6.
// A stalled result holds the input stage, which then drops sample.ready.
module obstacle_overtake_controller import ooc_pkg::*; #(
	parameter int WINDOW      = 5,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ooc_in_if.sink                sample,
	ooc_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CH     = 4;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
	localparam int LIM_W  = CFG_DATA_W + $clog2(WINDOW + 1);
	localparam int TH_W   = CFG_DATA_W + SPEED_W + $clog2(WINDOW + 1);
	localparam int MAG_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;
	localparam int CMP_W  = ((SUM_W > TH_W) ? SUM_W : TH_W) + 1;
	localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

	// Configuration registers
	logic [SPEED_W-1:0]    cruise_q, approach_q;
	logic [CFG_DATA_W-1:0] collide_q, side_lo_q, side_hi_q, front_clr_q;
	logic [CFG_DATA_W-1:0] rear_lo_q, rear_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_q    <= RST_CRUISE_SPEED;
			approach_q  <= RST_APPROACH_SPEED;
			collide_q   <= RST_COLLIDE_SCALE;
			side_lo_q   <= RST_SIDE_NEAR_LOW;
			side_hi_q   <= RST_SIDE_NEAR_HIGH;
			front_clr_q <= RST_FRONT_CLEAR_LIMIT;
			rear_lo_q   <= RST_REAR_CLEAR_LOW;
			rear_hi_q   <= RST_REAR_CLEAR_HIGH;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CRUISE_SPEED:      cruise_q    <= cfg_data[SPEED_W-1:0];
				REG_APPROACH_SPEED:    approach_q  <= cfg_data[SPEED_W-1:0];
				REG_COLLIDE_SCALE:     collide_q   <= cfg_data;
				REG_SIDE_NEAR_LOW:     side_lo_q   <= cfg_data;
				REG_SIDE_NEAR_HIGH:    side_hi_q   <= cfg_data;
				REG_FRONT_CLEAR_LIMIT: front_clr_q <= cfg_data;
				REG_REAR_CLEAR_LOW:    rear_lo_q   <= cfg_data;
				REG_REAR_CLEAR_HIGH:   rear_hi_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] samp_s1 [CH];
	logic                          res_valid_q;
	logic                          adv;

	assign adv          = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			samp_s1[0] <= sample.front_distance;
			samp_s1[1] <= sample.front_side_distance;
			samp_s1[2] <= sample.rear_side_distance;
			samp_s1[3] <= sample.rear_distance;
		end
	end

	// Sliding windows: a shift line per channel plus a running sum
	logic signed [SAMPLE_BITS-1:0] win_q [CH][WINDOW];
	logic signed [SUM_W-1:0]       sum_q [CH];
	logic signed [SUM_W-1:0]       sum_nx [CH];
	logic [SUM_W-1:0]              mag [CH];
	logic                          primed_q;

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			if (primed_q) begin
				sum_nx[c] = sum_q[c] - SUM_W'(win_q[c][WINDOW-1]) + SUM_W'(samp_s1[c]);
			end else begin
				sum_nx[c] = SUM_W'(samp_s1[c]) * WIN_S;
			end
			mag[c] = sum_nx[c][SUM_W-1] ? SUM_W'(-sum_nx[c]) : SUM_W'(sum_nx[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (adv) begin
			primed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < CH; c++) begin
				sum_q[c] <= sum_nx[c];
				for (int k = 0; k < WINDOW; k++) begin
					if (!primed_q || k == 0) begin
						win_q[c][k] <= samp_s1[c];
					end else begin
						win_q[c][k] <= win_q[c][k-1];
					end
				end
			end
		end
	end

	// Window thresholds (limit times WINDOW, no division)
	logic [MAG_W-1:0]        side_lo_w, side_hi_w, front_clr_w, rear_lo_w, rear_hi_w;
	logic [MAG_W-1:0]        fr_m, rr_m, rear_m;
	logic [TH_W-1:0]         collide_th;
	logic signed [CMP_W-1:0] front_x, collide_x;
	logic                    detect, fr_near, rr_near, fr_clear, rear_clear;
	logic [SPEED_W-1:0]      speed_q, speed_nx;

	assign side_lo_w   = MAG_W'(LIM_W'(side_lo_q) * LIM_W'(WINDOW));
	assign side_hi_w   = MAG_W'(LIM_W'(side_hi_q) * LIM_W'(WINDOW));
	assign front_clr_w = MAG_W'(LIM_W'(front_clr_q) * LIM_W'(WINDOW));
	assign rear_lo_w   = MAG_W'(LIM_W'(rear_lo_q) * LIM_W'(WINDOW));
	assign rear_hi_w   = MAG_W'(LIM_W'(rear_hi_q) * LIM_W'(WINDOW));
	assign fr_m        = MAG_W'(mag[1]);
	assign rr_m        = MAG_W'(mag[2]);
	assign rear_m      = MAG_W'(mag[3]);

	assign collide_th = TH_W'(collide_q) * TH_W'(speed_q) * TH_W'(WINDOW);
	assign front_x    = CMP_W'(sum_nx[0]);
	assign collide_x  = $signed(CMP_W'(collide_th));

	assign detect     = (speed_q != '0) && (front_x < collide_x);
	assign fr_near    = (fr_m > side_lo_w) && (fr_m < side_hi_w);
	assign rr_near    = (rr_m > side_lo_w) && (rr_m < side_hi_w);
	assign fr_clear   = fr_m < front_clr_w;
	assign rear_clear = (rear_m > rear_lo_w) && (rear_m < rear_hi_w);

	// Overtake sequencing
	ctrl_flags_t        flg_q, flg_nx;

	always_comb begin
		flg_nx   = flg_q;
		speed_nx = speed_q;
		if (detect && !flg_q.obstacle) begin
			flg_nx.obstacle = 1'b1;
			flg_nx.left     = 1'b0;
			flg_nx.right    = 1'b0;
			speed_nx        = '0;
		end else if (flg_q.obstacle) begin
			speed_nx    = approach_q;
			flg_nx.left = 1'b1;
			if (fr_near) begin
				flg_nx.side_seen = 1'b1;
			end
			if (rr_near && !flg_nx.beside && flg_nx.side_seen) begin
				flg_nx.left   = 1'b0;
				flg_nx.beside = 1'b1;
			end
			if (fr_clear && flg_nx.beside) begin
				flg_nx.right     = 1'b1;
				flg_nx.pass_done = 1'b1;
				speed_nx         = cruise_q;
			end
			if (flg_nx.pass_done) begin
				flg_nx.obstacle = 1'b0;
				flg_nx.beside   = 1'b0;
			end
			if (rear_clear) begin
				flg_nx.right = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_q   <= '0;
			speed_q <= RST_CRUISE_SPEED;
		end else if (adv) begin
			flg_q   <= flg_nx;
			speed_q <= speed_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || result.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.obstacle_active <= flg_nx.obstacle;
			result.left_blink      <= flg_nx.left;
			result.right_blink     <= flg_nx.right;
			result.drive_speed     <= speed_nx;
			result.passing_now     <= flg_nx.beside;
		end
	end

	assign result.valid = res_valid_q;

	// Checks
	a_beside_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		flg_q.beside |-> flg_q.side_seen)
		else $error("beside flag set without side seen");

	a_right_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		flg_q.right |-> flg_q.pass_done)
		else $error("right blinker set before pass completed");

	a_accept_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> valid_s1)
		else $error("accepted transaction did not reach input stage");

	a_primed_after_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> primed_q)
		else $error("windows not primed after first tick");

endmodule

FILE: test/obstacle_overtake_controller_tb.sv
// Self-checking testbench for the obstacle overtake controller.
`timescale 1ns / 100ps

module obstacle_overtake_controller_tb;
	import ooc_pkg::*;

	localparam int WINDOW       = 5;
	localparam int SAMPLE_BITS  = 12;
	localparam int SAMPLE_MAX   = 2047;
	localparam int SAMPLE_MIN   = -2048;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_AFTER   = 400;
	localparam int LONG_HOLD    = 160;
	localparam int PHASE_TICKS  = 200;
	localparam int SHOW_LIMIT   = 40;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t front;
		sample_t front_side;
		sample_t rear_side;
		sample_t rear;
	} sensor_tick_t;

	typedef struct packed {
		logic               obstacle;
		logic               left;
		logic               right;
		logic [SPEED_W-1:0] speed;
		logic               beside;
	} overtake_out_t;

	typedef enum {SET_RANDOM, SET_MAX, SET_ZERO} setting_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ooc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	ooc_out_if result_ch ();

	obstacle_overtake_controller #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stimulus and expected-output stores
	sensor_tick_t  tick_queue[$];
	overtake_out_t predicted_outputs[$];

	int error_count   = 0;
	int ticks_taken   = 0;
	int results_seen  = 0;
	int phases_run    = 0;
	int cycle_count   = 0;

	// Controller shadow state
	logic [CFG_DATA_W-1:0] reg_model [8];
	sample_t               window_buf [4][WINDOW];
	int                    buf_slot;
	bit                    windows_filled;
	bit                    avoiding;
	bit                    seen_side;
	bit                    alongside;
	bit                    overtaken;
	bit                    blink_l;
	bit                    blink_r;
	logic [SPEED_W-1:0]    speed_cmd;

	function automatic bit in_band(int mag, logic [CFG_DATA_W-1:0] lo,
			logic [CFG_DATA_W-1:0] hi);
		return mag > int'(lo) * WINDOW && mag < int'(hi) * WINDOW;
	endfunction

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	// One sensor tick: window update, then the overtake sequencing
	function automatic overtake_out_t advance_controller(sensor_tick_t t);
		sample_t       s [4];
		int            sum [4];
		int            c, k, fr, rr, rear;
		bit            detect;
		overtake_out_t o;
		s[0] = t.front;
		s[1] = t.front_side;
		s[2] = t.rear_side;
		s[3] = t.rear;
		for (c = 0; c < 4; c++) begin
			if (!windows_filled) begin
				for (k = 0; k < WINDOW; k++)
					window_buf[c][k] = s[c];
			end else begin
				window_buf[c][buf_slot] = s[c];
			end
		end
		if (!windows_filled) begin
			windows_filled = 1'b1;
			buf_slot = 0;
		end else begin
			buf_slot = (buf_slot + 1) % WINDOW;
		end
		for (c = 0; c < 4; c++) begin
			sum[c] = 0;
			for (k = 0; k < WINDOW; k++)
				sum[c] += window_buf[c][k];
		end

		detect = speed_cmd != 0 &&
			sum[0] < int'(reg_model[REG_COLLIDE_SCALE]) * WINDOW * int'(speed_cmd);
		fr   = magnitude(sum[1]);
		rr   = magnitude(sum[2]);
		rear = magnitude(sum[3]);

		if (detect && !avoiding) begin
			avoiding  = 1'b1;
			speed_cmd = '0;
			blink_l   = 1'b0;
			blink_r   = 1'b0;
		end else if (avoiding) begin
			speed_cmd = reg_model[REG_APPROACH_SPEED][SPEED_W-1:0];
			blink_l   = 1'b1;
			if (in_band(fr, reg_model[REG_SIDE_NEAR_LOW], reg_model[REG_SIDE_NEAR_HIGH]))
				seen_side = 1'b1;
			if (in_band(rr, reg_model[REG_SIDE_NEAR_LOW], reg_model[REG_SIDE_NEAR_HIGH]) &&
					!alongside && seen_side) begin
				blink_l   = 1'b0;
				alongside = 1'b1;
			end
			if (fr < int'(reg_model[REG_FRONT_CLEAR_LIMIT]) * WINDOW && alongside) begin
				blink_r   = 1'b1;
				overtaken = 1'b1;
				speed_cmd = reg_model[REG_CRUISE_SPEED][SPEED_W-1:0];
			end
			// pass_done is sticky: any later obstacle is dropped here
			if (overtaken) begin
				avoiding  = 1'b0;
				alongside = 1'b0;
			end
			if (in_band(rear, reg_model[REG_REAR_CLEAR_LOW], reg_model[REG_REAR_CLEAR_HIGH]))
				blink_r = 1'b0;
		end

		o.obstacle = avoiding;
		o.left     = blink_l;
		o.right    = blink_r;
		o.speed    = speed_cmd;
		o.beside   = alongside;
		return o;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= SHOW_LIMIT)
			$display("%0t: result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic compare_result(overtake_out_t got, overtake_out_t want);
		if (got.obstacle !== want.obstacle)
			report_mismatch($sformatf("obstacle_active %b, expected %b", got.obstacle,
				want.obstacle));
		if (got.left !== want.left)
			report_mismatch($sformatf("left_blink %b, expected %b", got.left, want.left));
		if (got.right !== want.right)
			report_mismatch($sformatf("right_blink %b, expected %b", got.right, want.right));
		if (got.speed !== want.speed)
			report_mismatch($sformatf("drive_speed %0d, expected %0d", got.speed, want.speed));
		if (got.beside !== want.beside)
			report_mismatch($sformatf("passing_now %b, expected %b", got.beside, want.beside));
	endtask

	// Sender: bursts of random length, random gaps between them
	sensor_tick_t next_tick;
	int           burst_left = 0;
	int           gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (gap_left != 0 || tick_queue.size() == 0) begin
				sample_ch.valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				next_tick = tick_queue.pop_front();
				sample_ch.valid               <= 1'b1;
				sample_ch.front_distance      <= next_tick.front;
				sample_ch.front_side_distance <= next_tick.front_side;
				sample_ch.rear_side_distance  <= next_tick.rear_side;
				sample_ch.rear_distance       <= next_tick.rear;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Accepted ticks feed the predictor
	sensor_tick_t seen_tick;

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			seen_tick.front      = sample_ch.front_distance;
			seen_tick.front_side = sample_ch.front_side_distance;
			seen_tick.rear_side  = sample_ch.rear_side_distance;
			seen_tick.rear       = sample_ch.rear_distance;
			predicted_outputs.push_back(advance_controller(seen_tick));
			ticks_taken <= ticks_taken + 1;
		end
	end

	// Receiver: rotating stall pattern, plus one long hold-off
	logic [31:0] rx_phase       = '0;
	logic [15:0] rx_pattern     = 16'hFFFF;
	int          hold_left      = 0;
	bit          long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			rx_phase <= rx_phase + 1;
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done  <= 1'b1;
				hold_left       <= LONG_HOLD;
				result_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left       <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= rx_pattern[rx_phase[3:0]];
				if (rx_phase[5:0] == 6'h3F)
					rx_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF :
						(16'($urandom) | 16'h0001);
			end
		end
	end

	// Result checker
	overtake_out_t got_out;

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got_out.obstacle = result_ch.obstacle_active;
			got_out.left     = result_ch.left_blink;
			got_out.right    = result_ch.right_blink;
			got_out.speed    = result_ch.drive_speed;
			got_out.beside   = result_ch.passing_now;
			if (predicted_outputs.size() == 0)
				report_mismatch("result with no tick outstanding");
			else
				compare_result(got_out, predicted_outputs.pop_front());
			results_seen <= results_seen + 1;
		end
	end

	task automatic queue_tick(int f, int fs, int rs, int r);
		sensor_tick_t t;
		t.front      = sample_t'(f);
		t.front_side = sample_t'(fs);
		t.rear_side  = sample_t'(rs);
		t.rear       = sample_t'(r);
		tick_queue.push_back(t);
	endtask

	// Value in [lo, hi], edges favored, sometimes negated, clamped to the field
	function automatic int pick_level(int lo, int hi);
		int v;
		if (lo > hi) begin
			v  = lo;
			lo = hi;
			hi = v;
		end
		case ($urandom_range(0, 3))
			0: v = lo;
			1: v = hi;
			default: v = lo + int'($urandom_range(0, hi - lo));
		endcase
		if ($urandom_range(0, 4) == 0)
			v = -v;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			v = SAMPLE_MIN;
		return v;
	endfunction

	// Overtake-shaped stretches (far, closing, side ramp, beside, clear) with noise
	task automatic queue_random_ticks(int count);
		int added, stage, len, n, c, thr;
		int lo [4];
		int hi [4];
		int v [4];
		added = 0;
		stage = 0;
		while (added < count) begin
			thr = int'(reg_model[REG_COLLIDE_SCALE]) * ($urandom_range(0, 1) ?
				int'(reg_model[REG_CRUISE_SPEED]) : int'(reg_model[REG_APPROACH_SPEED]));
			for (c = 0; c < 4; c++) begin
				lo[c] = 0;
				hi[c] = SAMPLE_MAX;
			end
			case (stage)
				0: begin
					lo[0] = thr + 1;
					hi[0] = thr + 400;
				end
				1: begin
					lo[0] = thr - 400;
					hi[0] = thr;
				end
				2: begin
					lo[1] = int'(reg_model[REG_SIDE_NEAR_LOW]);
					hi[1] = int'(reg_model[REG_SIDE_NEAR_HIGH]);
					hi[2] = int'(reg_model[REG_SIDE_NEAR_LOW]);
				end
				3: begin
					lo[1] = int'(reg_model[REG_SIDE_NEAR_LOW]);
					hi[1] = int'(reg_model[REG_SIDE_NEAR_HIGH]);
					lo[2] = int'(reg_model[REG_SIDE_NEAR_LOW]);
					hi[2] = int'(reg_model[REG_SIDE_NEAR_HIGH]);
				end
				4: begin
					hi[1] = int'(reg_model[REG_FRONT_CLEAR_LIMIT]);
					lo[3] = int'(reg_model[REG_REAR_CLEAR_LOW]);
					hi[3] = int'(reg_model[REG_REAR_CLEAR_HIGH]);
				end
				default: ;
			endcase
			len = $urandom_range(1, 7);
			for (n = 0; n < len; n++) begin
				for (c = 0; c < 4; c++)
					v[c] = ($urandom_range(0, 7) == 0) ? int'(sample_t'($urandom)) :
						pick_level(lo[c], hi[c]);
				queue_tick(v[0], v[1], v[2], v[3]);
				added++;
			end
			if (stage >= 4)
				stage = ($urandom_range(0, 3) == 0) ? 5 : 0;
			else
				stage = stage + 1;
		end
	endtask

	task automatic write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == REG_CRUISE_SPEED || idx == REG_APPROACH_SPEED)
			reg_model[idx] = value & {{(CFG_DATA_W-SPEED_W){1'b0}}, {SPEED_W{1'b1}}};
		else
			reg_model[idx] = value;
	endtask

	task automatic wait_idle();
		while (tick_queue.size() != 0 || sample_ch.valid || predicted_outputs.size() != 0)
			@(posedge clk);
	endtask

	// Drain, rewrite every register, then queue a batch of random ticks
	task automatic run_phase(setting_t setting);
		int i;
		logic [CFG_DATA_W-1:0] lo;
		wait_idle();
		repeat (4) @(posedge clk);
		case (setting)
			SET_MAX: begin
				for (i = 0; i < 8; i++)
					write_register(reg_idx_t'(i), '1);
			end
			SET_ZERO: begin
				for (i = 0; i < 8; i++)
					write_register(reg_idx_t'(i), '0);
			end
			default: begin
				// upper nibble exercises masking of the speed registers
				write_register(REG_CRUISE_SPEED, {4'($urandom), 4'($urandom_range(1, 15))});
				write_register(REG_APPROACH_SPEED, {4'($urandom), 4'($urandom_range(1, 15))});
				write_register(REG_COLLIDE_SCALE, 8'($urandom_range(0, 140)));
				lo = 8'($urandom_range(0, 60));
				write_register(REG_SIDE_NEAR_LOW, lo);
				write_register(REG_SIDE_NEAR_HIGH, 8'(lo + $urandom_range(0, 80)));
				write_register(REG_FRONT_CLEAR_LIMIT, 8'($urandom_range(0, 40)));
				lo = 8'($urandom_range(0, 60));
				write_register(REG_REAR_CLEAR_LOW, lo);
				write_register(REG_REAR_CLEAR_HIGH, 8'(lo + $urandom_range(0, 100)));
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		queue_random_ticks(PHASE_TICKS);
		phases_run++;
	endtask

	// Main sequence
	initial begin
		int c, k;
		arst_n                        = 1'b0;
		cfg_we                        = 1'b0;
		cfg_index                     = REG_CRUISE_SPEED;
		cfg_data                      = '0;
		sample_ch.valid               = 1'b0;
		sample_ch.front_distance      = '0;
		sample_ch.front_side_distance = '0;
		sample_ch.rear_side_distance  = '0;
		sample_ch.rear_distance       = '0;
		result_ch.ready               = 1'b0;

		reg_model[REG_CRUISE_SPEED]      = CFG_DATA_W'(RST_CRUISE_SPEED);
		reg_model[REG_APPROACH_SPEED]    = CFG_DATA_W'(RST_APPROACH_SPEED);
		reg_model[REG_COLLIDE_SCALE]     = RST_COLLIDE_SCALE;
		reg_model[REG_SIDE_NEAR_LOW]     = RST_SIDE_NEAR_LOW;
		reg_model[REG_SIDE_NEAR_HIGH]    = RST_SIDE_NEAR_HIGH;
		reg_model[REG_FRONT_CLEAR_LIMIT] = RST_FRONT_CLEAR_LIMIT;
		reg_model[REG_REAR_CLEAR_LOW]    = RST_REAR_CLEAR_LOW;
		reg_model[REG_REAR_CLEAR_HIGH]   = RST_REAR_CLEAR_HIGH;
		for (c = 0; c < 4; c++)
			for (k = 0; k < WINDOW; k++)
				window_buf[c][k] = '0;
		buf_slot       = 0;
		windows_filled = 1'b0;
		avoiding       = 1'b0;
		seen_side      = 1'b0;
		alongside      = 1'b0;
		overtaken      = 1'b0;
		blink_l        = 1'b0;
		blink_r        = 1'b0;
		speed_cmd      = RST_CRUISE_SPEED;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed overtake at reset settings; first tick fills the windows
		queue_tick(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
		queue_tick(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
		repeat (3) queue_tick(2000, 0, 0, 0);
		// minimum front readings pull the front sum below the threshold: detection
		repeat (2) queue_tick(SAMPLE_MIN, 0, 0, 0);
		// front side comes into the near band
		repeat (4) queue_tick(SAMPLE_MIN, 10, 0, 0);
		// rear side joins: beside the obstacle
		repeat (4) queue_tick(SAMPLE_MIN, 10, 10, 0);
		// front side clears: pass done, then a dropped re-detection
		repeat (5) queue_tick(SAMPLE_MIN, 0, 10, 0);
		// rear in its band clears the right blinker
		repeat (3) queue_tick(SAMPLE_MAX, 0, 0, 10);
		queue_random_ticks(PHASE_TICKS);
		phases_run++;

		run_phase(SET_RANDOM);
		run_phase(SET_RANDOM);
		run_phase(SET_MAX);
		run_phase(SET_RANDOM);
		// zero speeds last: once speed is zero with no obstacle it stays there
		run_phase(SET_ZERO);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Covered %0d sensor ticks over %0d register settings, %0d results checked.",
			ticks_taken, phases_run, results_seen);
		$display("Settings included reset values, random, all ones and all zeros; %0d errors.",
			error_count);
		if (error_count == 0)
			$display("obstacle_overtake_controller_tb OK");
		else
			$display("obstacle_overtake_controller_tb NOT OK");
		$finish;
	end

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
			predicted_outputs.size());
		$display("obstacle_overtake_controller_tb NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ooc_pkg.sv
rtl/core/ooc_if.sv
rtl/core/obstacle_overtake_controller.sv
test/obstacle_overtake_controller_tb.sv
